// ----- hdl/raster_to_block_reorder_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the raster-to-block reorder
// Shared property forms, clocked on i_clk and disabled while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef RASTER_TO_BLOCK_REORDER_ASSERT_SVH
`define RASTER_TO_BLOCK_REORDER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define R2B_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define R2B_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/r2b_pkg.sv -----
// ---------------------------------------------------------------------------
// r2b_pkg
// Types and constants shared by the raster-to-block reorder modules.
// ---------------------------------------------------------------------------
`default_nettype none

package r2b_pkg;

    localparam int MAX_BLOCKS_PER_LINE = 256;
    localparam int BLK_W               = $clog2(MAX_BLOCKS_PER_LINE);
    localparam int COL_W               = BLK_W + 3;
    localparam int LEN_W               = COL_W + 1;
    localparam int ROW_W               = 3;
    localparam int ADDR_W              = ROW_W + COL_W;
    localparam int STORE_DEPTH         = 1 << ADDR_W;
    localparam int CFG_W               = 9;
    localparam int PIX_W               = 8;
    localparam int IDX_W               = 8;
    localparam int BLK_ITEMS           = 64;
    localparam int ITEM_W              = $clog2(BLK_ITEMS);

    localparam logic [CFG_W-1:0]  LINE_BLOCKS_RESET = CFG_W'(80);
    localparam logic [CFG_W-1:0]  LINE_BLOCKS_MAX   = CFG_W'(MAX_BLOCKS_PER_LINE);
    localparam logic [ITEM_W-1:0] LAST_ITEM         = ITEM_W'(BLK_ITEMS - 1);
    localparam logic [ROW_W-1:0]  LAST_ROW          = ROW_W'(7);

    typedef enum logic {
        ST_INPUT,
        ST_EMIT
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic              accept;
        logic              rd_en;
        logic [ITEM_W-1:0] rd_idx;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic block_done;
        logic out_busy;
    } t_status;

endpackage

`default_nettype wire

// ----- hdl/r2b_ctrl.sv -----
// ---------------------------------------------------------------------------
// r2b_ctrl
// Sequencer: takes pixels, then walks the 64 reads of a completed block.
// ---------------------------------------------------------------------------
`default_nettype none

module r2b_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_s_tvalid,
    output logic                 o_s_tready,
    input  wire r2b_pkg::t_status i_status,
    output r2b_pkg::t_cmd        o_cmd
);
    import r2b_pkg::*;

    t_state            r_state, n_state;
    logic [ITEM_W-1:0] r_item, n_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INPUT;
            r_item  <= '0;
        end else begin
            r_state <= n_state;
            r_item  <= n_item;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_item        = r_item;
        o_s_tready    = 1'b0;
        o_cmd.accept  = 1'b0;
        o_cmd.rd_en   = 1'b0;
        o_cmd.rd_idx  = r_item;
        unique case (r_state)
            ST_INPUT: begin
                o_s_tready   = 1'b1;
                o_cmd.accept = i_s_tvalid;
                if (i_s_tvalid && i_status.block_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // A read is issued only when the output register can take its data.
                o_cmd.rd_en = !i_status.out_busy;
                if (!i_status.out_busy) begin
                    if (r_item == LAST_ITEM) begin
                        n_item  = '0;
                        n_state = ST_INPUT;
                    end else begin
                        n_item = r_item + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_INPUT;
            end
        endcase
    end

    `include "raster_to_block_reorder_assert.svh"

    `R2B_ASSERT_NEXT(a_last_read_returns, o_cmd.rd_en && (r_item == LAST_ITEM), r_state == ST_INPUT && r_item == '0, "sequencer did not return to input after the last read")
    `R2B_ASSERT_NEXT(a_done_starts_emit, o_cmd.accept && i_status.block_done, r_state == ST_EMIT && r_item == '0, "completed block did not start an emit pass")

endmodule

`default_nettype wire

// ----- hdl/r2b_datapath.sv -----
// ---------------------------------------------------------------------------
// r2b_datapath
// Strip store, position counters and the registered output stage.
// ---------------------------------------------------------------------------
`default_nettype none

module r2b_datapath (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_wr_en,
    input  wire logic [r2b_pkg::CFG_W-1:0]    i_cfg_wr_data,
    input  wire logic [r2b_pkg::PIX_W-1:0]    i_pixel,
    input  wire logic                         i_sof,
    input  wire r2b_pkg::t_cmd                i_cmd,
    output r2b_pkg::t_status                  o_status,
    input  wire logic                         i_m_tready,
    output logic                              o_m_tvalid,
    output logic [r2b_pkg::PIX_W-1:0]         o_out_pixel,
    output logic [r2b_pkg::IDX_W-1:0]         o_block_index,
    output logic                              o_block_last
);
    import r2b_pkg::*;

    logic [CFG_W-1:0]  r_line_blocks;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [BLK_W-1:0]  r_base;
    logic [PIX_W-1:0]  r_mem [STORE_DEPTH];
    logic [PIX_W-1:0]  r_rdata;
    logic [IDX_W-1:0]  r_index;
    logic              r_last;
    logic              r_dvalid;

    logic [CFG_W-1:0]  eff_blocks;
    logic [LEN_W-1:0]  line_len;
    logic [COL_W-1:0]  cur_col;
    logic [ROW_W-1:0]  cur_row;
    logic [LEN_W-1:0]  col_inc;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;

    // Width outside the supported range is clamped to it.
    always_comb begin
        if (r_line_blocks == '0) begin
            eff_blocks = CFG_W'(1);
        end else if (r_line_blocks > LINE_BLOCKS_MAX) begin
            eff_blocks = LINE_BLOCKS_MAX;
        end else begin
            eff_blocks = r_line_blocks;
        end
        line_len = LEN_W'({eff_blocks, 3'b000});
    end

    always_comb begin
        if (i_sof || (LEN_W'(r_col) >= line_len)) begin
            cur_col = '0;
        end else begin
            cur_col = r_col;
        end
        cur_row = i_sof ? '0 : r_row;
        col_inc = LEN_W'(cur_col) + 1'b1;
        if (col_inc >= line_len) begin
            n_col = '0;
            n_row = cur_row + 1'b1;
        end else begin
            n_col = col_inc[COL_W-1:0];
            n_row = cur_row;
        end
        wr_addr = {cur_row, cur_col};
        rd_addr = {i_cmd.rd_idx[ITEM_W-1:3], r_base, i_cmd.rd_idx[2:0]};
    end

    assign o_status.block_done = (cur_row == LAST_ROW) && (cur_col[2:0] == 3'b111);
    assign o_status.out_busy   = r_dvalid && !i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_blocks <= LINE_BLOCKS_RESET;
            r_col         <= '0;
            r_row         <= '0;
        end else if (i_cfg_wr_en) begin
            r_line_blocks <= i_cfg_wr_data;
            r_col         <= '0;
            r_row         <= '0;
        end else if (i_cmd.accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && o_status.block_done) begin
            r_base <= cur_col[COL_W-1:3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mem[wr_addr] <= i_pixel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[rd_addr];
            r_index <= IDX_W'(r_base);
            r_last  <= (i_cmd.rd_idx == LAST_ITEM);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dvalid <= 1'b0;
        end else if (i_cmd.rd_en) begin
            r_dvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_dvalid <= 1'b0;
        end
    end

    assign o_m_tvalid    = r_dvalid;
    assign o_out_pixel   = r_rdata;
    assign o_block_index = r_index;
    assign o_block_last  = r_last;

    `include "raster_to_block_reorder_assert.svh"

    `R2B_ASSERT_SAME(a_read_into_free_reg, i_cmd.rd_en, !r_dvalid || i_m_tready, "read issued while a result is stalled")
    `R2B_ASSERT_SAME(a_no_write_during_read, i_cmd.accept, !i_cmd.rd_en, "store written during a block read pass")

endmodule

`default_nettype wire

// ----- hdl/raster_to_block_reorder.sv -----
// ---------------------------------------------------------------------------
// raster_to_block_reorder
// Reorders raster grey pixels into 8x8 blocks for a JPEG encoder front end.
// ---------------------------------------------------------------------------
// Pixels enter on the slave stream, one item per handshake, with tuser high on
// the first pixel of a frame. The configuration write sets the line width in
// blocks of 8 pixels and restarts the strip; write it only while idle.
// Each pixel goes into an eight-line strip store. The pixel that completes a
// block (row 7 of the strip, last column of the block) makes the block send
// its 64 pixels in row-major order on the master stream, tlast on the last.
// The first block pixel is valid once the sequencer has entered its emit
// state and the first read has filled the output register; the block then
// streams one item per cycle while the receiver does not stall. Input is held
// off while a block is read out, since the store has one read and one write
// port.
// A receiver stall freezes the output register and pauses the reads; the last
// pixel of a block may still wait while new input is taken.
// Reset clears the counters, the output valid and sets the width to 80 blocks.
// An unfinished final strip is never sent.
// ---------------------------------------------------------------------------
`default_nettype none

module raster_to_block_reorder (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_wr_en,
    input  wire logic [r2b_pkg::CFG_W-1:0] i_cfg_wr_data,
    input  wire logic                      i_s_tvalid,
    output logic                           o_s_tready,
    input  wire logic [7:0]                i_s_tdata,   // [7:0] pixel
    input  wire logic                      i_s_tuser,   // [0] start_of_frame
    output logic                           o_m_tvalid,
    input  wire logic                      i_m_tready,
    output logic [15:0]                    o_m_tdata,   // [7:0] out_pixel, [15:8] block_index
    output logic                           o_m_tlast    // block_last
);
    import r2b_pkg::*;

    t_cmd             cmd;
    t_status          status;
    logic [PIX_W-1:0] out_pixel;
    logic [IDX_W-1:0] block_index;

    r2b_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    r2b_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_pixel       (i_s_tdata),
        .i_sof         (i_s_tuser),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_m_tready    (i_m_tready),
        .o_m_tvalid    (o_m_tvalid),
        .o_out_pixel   (out_pixel),
        .o_block_index (block_index),
        .o_block_last  (o_m_tlast)
    );

    assign o_m_tdata = {block_index, out_pixel};

endmodule

`default_nettype wire
